// File: sv/sit_pkg.sv
package sit_pkg;

  // Fixed field widths of the request and result items.
  localparam int FUNC_W   = 1;
  localparam int VIDX_W   = 12;
  localparam int JOINT_W  = 8;
  localparam int WEIGHT_W = 16;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 13;

  // Result slots on the port, and the width of a sum of four raw weights.
  localparam int SLOTS  = 4;
  localparam int SUM_W  = 18;
  localparam int SLOT_W = 2;

  // Q1.15 one.
  localparam logic [WEIGHT_W-1:0] ONE_Q15 = 16'h8000;

  // Request function codes.
  localparam logic [FUNC_W-1:0] FUNC_ADD  = 1'b0;
  localparam logic [FUNC_W-1:0] FUNC_READ = 1'b1;

  // Result status codes.
  localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

  // Response of the divider to the controller.
  typedef struct packed {
    logic                done;
    logic [WEIGHT_W-1:0] quotient;
  } div_rsp_t;

endpackage

// File: sv/sit_if.sv
// Request channel: one add or read request per handshake.
interface sit_item_if;
  import sit_pkg::*;

  logic                valid;
  logic                ready;
  logic [FUNC_W-1:0]   func;
  logic [VIDX_W-1:0]   vertex_index;
  logic [JOINT_W-1:0]  joint_index;
  logic [WEIGHT_W-1:0] weight;

  modport source (output valid, func, vertex_index, joint_index, weight, input ready);
  modport sink (input valid, func, vertex_index, joint_index, weight, output ready);
endinterface

// Result channel: one result per request.
interface sit_result_if;
  import sit_pkg::*;

  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [WEIGHT_W-1:0] weight_a;
  logic [WEIGHT_W-1:0] weight_b;
  logic [WEIGHT_W-1:0] weight_c;
  logic [WEIGHT_W-1:0] weight_d;
  logic [JOINT_W-1:0]  joint_a;
  logic [JOINT_W-1:0]  joint_b;
  logic [JOINT_W-1:0]  joint_c;
  logic [JOINT_W-1:0]  joint_d;

  modport source (
    output valid, status, weight_a, weight_b, weight_c, weight_d,
           joint_a, joint_b, joint_c, joint_d,
    input  ready
  );
  modport sink (
    input  valid, status, weight_a, weight_b, weight_c, weight_d,
           joint_a, joint_b, joint_c, joint_d,
    output ready
  );
endinterface

// File: sv/sit_ram.sv
module sit_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: sv/sit_div.sv
module sit_div (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [sit_pkg::WEIGHT_W-1:0] dividend,
  input  logic [sit_pkg::SUM_W-1:0]    divisor,
  output sit_pkg::div_rsp_t            rsp
);
  import sit_pkg::*;

  // Four quotient bits are resolved in each cycle.
  localparam int STEPS = 4;

  logic                busy;
  logic [1:0]          cnt;
  logic                done;
  logic [SUM_W-1:0]    rem;
  logic [SUM_W-1:0]    rem_next;
  logic [WEIGHT_W-1:0] low;
  logic [WEIGHT_W-1:0] low_next;
  logic [WEIGHT_W-1:0] quo;
  logic [WEIGHT_W-1:0] quo_next;
  logic [SUM_W-1:0]    dsr;

  // Restoring division of weight * 2^15 by the sum, several bits per cycle.
  always_comb begin
    logic [SUM_W:0] trial;
    rem_next = rem;
    low_next = low;
    quo_next = quo;
    for (int i = 0; i < STEPS; i++) begin
      trial    = {rem_next, low_next[WEIGHT_W-1]};
      low_next = {low_next[WEIGHT_W-2:0], 1'b0};
      if (trial >= {1'b0, dsr}) begin
        rem_next = SUM_W'(trial - {1'b0, dsr});
        quo_next = {quo_next[WEIGHT_W-2:0], 1'b1};
      end else begin
        rem_next = trial[SUM_W-1:0];
        quo_next = {quo_next[WEIGHT_W-2:0], 1'b0};
      end
    end
  end

  // Control: a start loads the operands, the counter then runs through four steps, then done pulses.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 2'd1;
        if (cnt == 2'd3) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: the upper dividend bits start the remainder, they are below the divisor.
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= SUM_W'(dividend[WEIGHT_W-1:1]);
      low <= {dividend[0], {(WEIGHT_W-1){1'b0}}};
      quo <= '0;
      dsr <= divisor;
    end else if (busy) begin
      rem <= rem_next;
      low <= low_next;
      quo <= quo_next;
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = quo;

endmodule

// File: sv/skin_influence_table.sv
// Skinning influence table: each vertex holds up to MAX_INFLUENCES (joint, weight)
// slots in one synchronous memory entry. An add request with a joint below JOINT_COUNT
// stores its joint and weight in the first slot whose weight is zero; an add returns
// status ok, out of range or full; a read request returns the slot weights scaled to
// sum to one in Q1.15, rounded down, with their joints. After reset the block sweeps
// the memory to zero, one vertex per cycle, through every address before it takes its
// first request. One request is worked at a time. An add, an out-of-range request or a
// read of an empty vertex goes from the read state straight to the done state. A read of
// a vertex with weight goes through the divide state, where the shared
// four-bit-per-cycle divider scales one slot at a time. In the done state the result
// is loaded into an output register once it is free, and the next request can then be
// taken. A result waits in the output register while the next request is accepted; a
// result that is ready before the previous one has left holds the block until it has.
module skin_influence_table #(
  parameter int VERTEX_DEPTH   = 4096,
  parameter int MAX_INFLUENCES = 4,
  parameter int JOINT_COUNT    = 256
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [sit_pkg::COUNT_W-1:0] cfg_wdata,
  sit_item_if.sink                    item,
  sit_result_if.source                result
);
  import sit_pkg::*;

  localparam int ADDR_W  = (VERTEX_DEPTH > 1) ? $clog2(VERTEX_DEPTH) : 1;
  localparam int ENTRY_W = MAX_INFLUENCES * (WEIGHT_W + JOINT_W);
  localparam int JOFS    = MAX_INFLUENCES * WEIGHT_W;
  localparam logic [16:0]       DEPTH_L   = 17'(VERTEX_DEPTH);
  localparam logic [10:0]       JCOUNT_L  = 11'(JOINT_COUNT);
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(VERTEX_DEPTH - 1);
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(MAX_INFLUENCES - 1);

  typedef enum logic [4:0] {
    ST_CLEAR = 5'b00001,
    ST_IDLE  = 5'b00010,
    ST_READ  = 5'b00100,
    ST_DIV   = 5'b01000,
    ST_DONE  = 5'b10000
  } state_t;

  state_t              state;
  state_t              state_next;
  logic [ADDR_W-1:0]   clr_addr;
  logic [COUNT_W-1:0]  vertex_count;

  logic [FUNC_W-1:0]   req_func;
  logic [JOINT_W-1:0]  req_joint;
  logic [WEIGHT_W-1:0] req_weight;
  logic                req_oor;
  logic [ADDR_W-1:0]   req_addr;

  logic [STATUS_W-1:0] res_status;
  logic [WEIGHT_W-1:0] res_w [SLOTS];
  logic [JOINT_W-1:0]  res_j [SLOTS];
  logic [WEIGHT_W-1:0] raw_w [SLOTS];
  logic [SUM_W-1:0]    sum_r;
  logic [SLOT_W-1:0]   slot;

  logic                out_valid;
  logic [STATUS_W-1:0] out_status;
  logic [WEIGHT_W-1:0] out_w [SLOTS];
  logic [JOINT_W-1:0]  out_j [SLOTS];

  logic                ram_we;
  logic [ADDR_W-1:0]   ram_waddr;
  logic [ENTRY_W-1:0]  ram_wdata;
  logic [ENTRY_W-1:0]  ram_rdata;
  logic [ENTRY_W-1:0]  new_entry;

  logic [WEIGHT_W-1:0] rd_w [SLOTS];
  logic [JOINT_W-1:0]  rd_j [SLOTS];
  logic [SUM_W-1:0]    rd_sum;
  logic                free_found;
  logic                joint_ok;
  logic                in_range;
  logic                accept;
  logic                out_load;

  logic                div_start;
  logic [WEIGHT_W-1:0] div_dividend;
  logic [SUM_W-1:0]    div_divisor;
  div_rsp_t            div_rsp;

  assign accept = item.valid & item.ready;
  assign item.ready = (state == ST_IDLE);

  // A vertex is in range below both the register and the store depth.
  assign in_range = (13'(item.vertex_index) < vertex_count) &&
                    (17'(item.vertex_index) < DEPTH_L);
  assign joint_ok = (11'(req_joint) < JCOUNT_L);

  // Unpack the entry read back, add the weights and place an add in the first empty slot.
  always_comb begin
    logic placed;
    rd_sum    = '0;
    placed    = 1'b0;
    new_entry = ram_rdata;
    for (int s = 0; s < SLOTS; s++) begin
      rd_w[s] = '0;
      rd_j[s] = '0;
    end
    for (int s = 0; s < MAX_INFLUENCES; s++) begin
      rd_w[s] = ram_rdata[s*WEIGHT_W +: WEIGHT_W];
      rd_j[s] = ram_rdata[JOFS + s*JOINT_W +: JOINT_W];
      rd_sum  = rd_sum + SUM_W'(rd_w[s]);
      if (!placed && rd_w[s] == '0) begin
        placed = 1'b1;
        new_entry[s*WEIGHT_W +: WEIGHT_W]       = req_weight;
        new_entry[JOFS + s*JOINT_W +: JOINT_W] = req_joint;
      end
    end
    free_found = placed;
  end

  // Memory write: the clearing sweep, or the write-back of an add.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = req_addr;
    ram_wdata = new_entry;
    if (state == ST_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr;
      ram_wdata = '0;
    end else if (state == ST_READ && req_func == FUNC_ADD && !req_oor &&
                 joint_ok && free_found) begin
      ram_we = 1'b1;
    end
  end

  sit_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (VERTEX_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ADDR_W'(item.vertex_index)),
    .rdata (ram_rdata)
  );

  // Divider start: first slot straight from memory, later slots from the held weights.
  always_comb begin
    div_start    = 1'b0;
    div_dividend = raw_w[SLOT_W'(slot + 2'd1)];
    div_divisor  = sum_r;
    if (state == ST_READ) begin
      div_start    = (req_func == FUNC_READ) && !req_oor && (rd_sum != '0);
      div_dividend = rd_w[0];
      div_divisor  = rd_sum;
    end else if (state == ST_DIV) begin
      div_start = div_rsp.done && (slot != LAST_SLOT);
    end
  end

  sit_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .rsp      (div_rsp)
  );

  assign out_load = (state == ST_DONE) && (!out_valid || result.ready);

  // Sequencer.
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (clr_addr == LAST_ADDR) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) state_next = ST_READ;
      end
      ST_READ: begin
        state_next = div_start ? ST_DIV : ST_DONE;
      end
      ST_DIV: begin
        if (div_rsp.done && slot == LAST_SLOT) state_next = ST_DONE;
      end
      ST_DONE: begin
        if (out_load) state_next = ST_IDLE;
      end
      default: state_next = ST_CLEAR;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_CLEAR;
      clr_addr     <= '0;
      vertex_count <= '0;
      out_valid    <= 1'b0;
      slot         <= '0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) clr_addr <= clr_addr + ADDR_W'(1);
      if (cfg_we) vertex_count <= cfg_wdata;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
      if (state == ST_READ) begin
        slot <= '0;
      end else if (state == ST_DIV && div_rsp.done) begin
        slot <= slot + 2'd1;
      end
    end
  end

  // Request capture and result assembly.
  always_ff @(posedge clk) begin
    if (accept) begin
      req_func   <= item.func;
      req_joint  <= item.joint_index;
      req_weight <= item.weight;
      req_oor    <= !in_range;
      req_addr   <= ADDR_W'(item.vertex_index);
    end
    if (state == ST_READ) begin
      sum_r <= rd_sum;
      if (req_oor) begin
        res_status <= STATUS_RANGE;
      end else if (req_func == FUNC_ADD) begin
        res_status <= (joint_ok && !free_found) ? STATUS_FULL : STATUS_OK;
      end else begin
        res_status <= STATUS_OK;
      end
      // Adds and out-of-range requests return empty slots; an empty vertex reads as joint 0.
      for (int s = 0; s < SLOTS; s++) begin
        raw_w[s] <= rd_w[s];
        if (req_oor || req_func == FUNC_ADD) begin
          res_w[s] <= '0;
          res_j[s] <= '0;
        end else if (s == 0 && rd_sum == '0) begin
          res_w[s] <= ONE_Q15;
          res_j[s] <= '0;
        end else begin
          res_w[s] <= '0;
          res_j[s] <= rd_j[s];
        end
      end
    end
    if (state == ST_DIV && div_rsp.done) begin
      res_w[slot] <= div_rsp.quotient;
    end
    if (out_load) begin
      out_status <= res_status;
      for (int s = 0; s < SLOTS; s++) begin
        out_w[s] <= res_w[s];
        out_j[s] <= res_j[s];
      end
    end
  end

  assign result.valid    = out_valid;
  assign result.status   = out_status;
  assign result.weight_a = out_w[0];
  assign result.weight_b = out_w[1];
  assign result.weight_c = out_w[2];
  assign result.weight_d = out_w[3];
  assign result.joint_a  = out_j[0];
  assign result.joint_b  = out_j[1];
  assign result.joint_c  = out_j[2];
  assign result.joint_d  = out_j[3];

endmodule
